FILE: rtl/core/crcfr_pkg.sv
// ============================================================================
// crcfr_pkg
// Shared types, codes and the CRC-32/MPEG-2 byte step for the frame receiver.
// ============================================================================
package crcfr_pkg;

    // input beat kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // result beat kinds
    localparam logic OUT_PAYLOAD = 1'b0;
    localparam logic OUT_REPORT  = 1'b1;

    // configuration register indexes
    localparam logic REG_START_BYTE = 1'b0;
    localparam logic REG_TIMEOUT    = 1'b1;

    localparam logic [7:0]  START_BYTE_RST = 8'hAA;
    localparam logic [15:0] TIMEOUT_RST    = 16'd2000;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CRC  = 2'd1,
        ST_TIMEOUT  = 2'd2,
        ST_TOO_LONG = 2'd3
    } status_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_value;
    } item_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] payload_value;
        logic [8:0] payload_index;
        logic [7:0] command;
        logic [15:0] frame_length;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } step_t;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [15:0] byte_timeout_ticks;
    } cfg_t;

    // MSB-first CRC update over one byte, no reflection
    function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h0};
        for (int k = 0; k < 8; k++)
        begin
            if (c[31])
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/crcfr_in_if.sv
// ============================================================================
// crcfr_in_if
// Input channel: received bytes and time ticks, valid/ready.
// ============================================================================
interface crcfr_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_value;

    modport source (output valid, output kind, output rx_value, input ready);
    modport sink   (input valid, input kind, input rx_value, output ready);
endinterface

FILE: rtl/core/crcfr_out_if.sv
// ============================================================================
// crcfr_out_if
// Result channel: payload beats and frame-end reports, valid/ready.
// ============================================================================
interface crcfr_out_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [7:0]  payload_value;
    logic [8:0]  payload_index;
    logic [7:0]  command;
    logic [15:0] frame_length;
    logic [1:0]  status;

    modport source (output valid, output out_kind, output payload_value,
                    output payload_index, output command, output frame_length,
                    output status, input ready);
    modport sink   (input valid, input out_kind, input payload_value,
                    input payload_index, input command, input frame_length,
                    input status, output ready);
endinterface

FILE: rtl/core/crc_checked_frame_receiver_unit.sv
// ============================================================================
// crc_checked_frame_receiver_unit
// Start-of-frame / length / CRC-32/MPEG-2 frame receiver, top level.
// ============================================================================
// Feed received bytes (kind 0) and time ticks (kind 1) on rx. Bytes are dropped
// until one equals start_byte; then come a command byte, a little-endian
// 16-bit length, the payload and a little-endian CRC-32/MPEG-2 over command,
// length and payload. Each payload byte leaves on res as it arrives, and every
// frame closes with one report beat (out_kind 1) carrying command, length and
// status: ok, bad CRC, inter-byte timeout or length beyond MAX_CHUNK_BYTES + 4.
// Payload of a frame whose report is not ok must be thrown away downstream.
// Throughput is one beat per cycle while res is ready. A beat is held in the
// input register, then goes through the frame state update (the CRC byte
// step sets the longest path) into the result register that drives res; a
// stall on res keeps it in the input register. Configuration writes belong
// to idle periods only.
// ============================================================================
module crc_checked_frame_receiver_unit #(
    parameter int MAX_CHUNK_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    crcfr_in_if.sink    rx,
    crcfr_out_if.source res,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import crcfr_pkg::*;

    // configuration registers
    cfg_t    cfg_reg;

    // input register
    logic    in_valid_reg;
    item_t   in_item_reg;

    // result register
    logic    out_valid_reg;
    result_t out_data_reg;

    step_t   step;
    logic    advance;

    // the held beat moves on when the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte         <= START_BYTE_RST;
            cfg_reg.byte_timeout_ticks <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_BYTE: cfg_reg.start_byte         <= cfg_data[7:0];
                REG_TIMEOUT:    cfg_reg.byte_timeout_ticks <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx.ready)
            in_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_item_reg.kind     <= rx.kind;
            in_item_reg.rx_value <= rx.rx_value;
        end
    end

    crcfr_parser #(
        .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .step    (step)
    );

    // a beat that yields no result still empties the slot it was granted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= step.valid;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step.valid)
            out_data_reg <= step.data;
    end

    assign res.valid         = out_valid_reg;
    assign res.out_kind      = out_data_reg.out_kind;
    assign res.payload_value = out_data_reg.payload_value;
    assign res.payload_index = out_data_reg.payload_index;
    assign res.command       = out_data_reg.command;
    assign res.frame_length  = out_data_reg.frame_length;
    assign res.status        = out_data_reg.status;

endmodule

FILE: rtl/core/crcfr_parser.sv
// ============================================================================
// crcfr_parser
// Frame state and one-beat update: hunt, header, payload, CRC, timeout.
// ============================================================================
module crcfr_parser #(
    parameter int MAX_CHUNK_BYTES = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  crcfr_pkg::item_t item,
    input  crcfr_pkg::cfg_t  cfg,
    output crcfr_pkg::step_t step
);
    import crcfr_pkg::*;

    localparam int          CNT_BITS  = $clog2(MAX_CHUNK_BYTES + 5);
    localparam int          CNT_W     = (CNT_BITS > 9) ? CNT_BITS : 9;
    localparam logic [16:0] BUF_LIMIT = 17'(MAX_CHUNK_BYTES + 4);

    typedef enum logic [2:0] {
        PH_HUNT, PH_CMD, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_CRC
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         cmd_reg, cmd_next;
    logic [15:0]        len_reg, len_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [31:0]        crc_reg, crc_next;
    logic [31:0]        rcrc_reg, rcrc_next;
    logic [15:0]        idle_reg, idle_next;

    logic [31:0]        crc_fed;
    logic [CNT_W-1:0]   cnt_inc;
    logic [15:0]        len_full;
    logic [31:0]        rcrc_upd;
    logic [4:0]         rcrc_lane;

    assign crc_fed   = crc_feed(crc_reg, item.rx_value);
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign len_full  = {item.rx_value, len_reg[7:0]};
    assign rcrc_lane = {cnt_reg[1:0], 3'b000};

    always_comb
    begin
        rcrc_upd = rcrc_reg;
        rcrc_upd[rcrc_lane +: 8] = rcrc_reg[rcrc_lane +: 8] | item.rx_value;
    end

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        rcrc_next  = rcrc_reg;
        idle_next  = idle_reg;
        step       = '0;

        if (item.kind == KIND_TICK)
        begin
            if (phase_reg != PH_HUNT)
            begin
                idle_next = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
                if (idle_next >= cfg.byte_timeout_ticks)
                begin
                    step.valid             = 1'b1;
                    step.data.out_kind     = OUT_REPORT;
                    step.data.command      = cmd_reg;
                    step.data.frame_length = len_reg;
                    step.data.status       = ST_TIMEOUT;
                    phase_next             = PH_HUNT;
                    idle_next              = '0;
                end
            end
        end
        else
        begin
            idle_next = '0;
            unique case (phase_reg)
                PH_CMD:
                begin
                    cmd_next   = item.rx_value;
                    crc_next   = crc_fed;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next   = {8'h00, item.rx_value};
                    crc_next   = crc_fed;
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next = len_full;
                    crc_next = crc_fed;
                    if ({1'b0, len_full} > BUF_LIMIT)
                    begin
                        step.valid             = 1'b1;
                        step.data.out_kind     = OUT_REPORT;
                        step.data.command      = cmd_reg;
                        step.data.frame_length = len_full;
                        step.data.status       = ST_TOO_LONG;
                        phase_next             = PH_HUNT;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        phase_next = (len_full == 16'h0000) ? PH_CRC : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    crc_next                = crc_fed;
                    step.valid              = 1'b1;
                    step.data.out_kind      = OUT_PAYLOAD;
                    step.data.payload_value = item.rx_value;
                    step.data.payload_index = cnt_reg[8:0];
                    cnt_next                = cnt_inc;
                    if (16'(cnt_inc) >= len_reg)
                    begin
                        cnt_next   = '0;
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    rcrc_next = rcrc_upd;
                    cnt_next  = cnt_inc;
                    if (cnt_inc >= CNT_W'(4))
                    begin
                        step.valid             = 1'b1;
                        step.data.out_kind     = OUT_REPORT;
                        step.data.command      = cmd_reg;
                        step.data.frame_length = len_reg;
                        step.data.status       = (rcrc_upd == crc_reg) ? ST_OK : ST_BAD_CRC;
                        phase_next             = PH_HUNT;
                    end
                end
                default:
                begin
                    if (item.rx_value == cfg.start_byte)
                    begin
                        phase_next = PH_CMD;
                        cmd_next   = '0;
                        len_next   = '0;
                        cnt_next   = '0;
                        crc_next   = CRC_INIT;
                        rcrc_next  = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            cmd_reg   <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            crc_reg   <= CRC_INIT;
            rcrc_reg  <= '0;
            idle_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
            rcrc_reg  <= rcrc_next;
            idle_reg  <= idle_next;
        end
    end

endmodule

FILE: verif/crc_checked_frame_receiver_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// crc_checked_frame_receiver_unit_test
// Self-checking bench for the CRC-32/MPEG-2 frame receiver. A local deframer
// tracks hunt/command/length/payload/CRC state per accepted rx beat and
// queues the payload and report beats it expects; every res beat is compared
// field by field in order. Directed frames cover the register defaults, edges and
// a hold-off; random frames follow, with faults, noise and stalls.
// ============================================================================
module crc_checked_frame_receiver_unit_test;
    import crcfr_pkg::*;

    localparam int CHUNK_BYTES   = 256;
    localparam int BUF_LIMIT     = CHUNK_BYTES + 4; // longest legal payload
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;               // two-stage pipe plus margin

    // deframer phase, tracked beat by beat
    typedef enum logic [2:0] {
        SEEK_START,
        GET_CMD,
        GET_LEN_LO,
        GET_LEN_HI,
        GET_PAYLOAD,
        GET_CRC
    } frame_phase_e;

    // how a generated frame is spoilt
    typedef enum logic [1:0] {
        FAULT_NONE,
        FAULT_CRC,
        FAULT_TIMEOUT,
        FAULT_TOO_LONG
    } frame_fault_e;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    crcfr_in_if  rx_if ();
    crcfr_out_if res_if ();

    crc_checked_frame_receiver_unit #(
        .MAX_CHUNK_BYTES(CHUNK_BYTES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx_if),
        .res      (res_if),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // register copies, updated as they are written
    logic [7:0]   cfg_start   = START_BYTE_RST;
    logic [15:0]  cfg_timeout = TIMEOUT_RST;

    // deframer state
    frame_phase_e fr_phase    = SEEK_START;
    logic [7:0]   fr_command  = '0;
    logic [15:0]  fr_length   = '0;
    logic [8:0]   fr_count    = '0;
    logic [31:0]  fr_crc      = CRC_INIT;
    logic [31:0]  fr_crc_rx   = '0;
    logic [15:0]  fr_idle     = '0;

    result_t      deframed_beats[$];

    int           fail_count    = 0;
    int           cycle_count   = 0;
    int           frame_items   = 0;
    int           hold_off_req  = 0;
    bit           gaps_on       = 1'b1;
    bit           stalls_on     = 1'b1;

    // ------------------------------------------------------------------------
    // clock, cycle guard
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // CRC-32/MPEG-2, one byte, fed bit by bit MSB first
    // ------------------------------------------------------------------------
    function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] s;
        logic        fb;
        s = c;
        for (int i = 7; i >= 0; i--)
        begin
            fb = s[31] ^ d[i];
            s  = {s[30:0], 1'b0};
            if (fb)
                s = s ^ CRC_POLY;
        end
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // deframer: expected res beats for one accepted rx beat
    // ------------------------------------------------------------------------
    task automatic close_frame(input status_t st);
        result_t beat;
        beat              = '0;
        beat.out_kind     = OUT_REPORT;
        beat.command      = fr_command;
        beat.frame_length = fr_length;
        beat.status       = st;
        deframed_beats.push_back(beat);
        fr_phase = SEEK_START;
        fr_idle  = '0;
    endtask

    task automatic deframe_beat(input logic k, input logic [7:0] b);
        result_t beat;
        beat = '0;
        if (k == KIND_TICK)
        begin
            // ticks only count once a frame is open
            if (fr_phase != SEEK_START)
            begin
                if (fr_idle != 16'hFFFF)
                    fr_idle++;
                if (fr_idle >= cfg_timeout)
                    close_frame(ST_TIMEOUT);
            end
        end
        else
        begin
            fr_idle = '0;
            case (fr_phase)
                GET_CMD:
                begin
                    fr_command = b;
                    fr_crc     = crc_next(fr_crc, b);
                    fr_phase   = GET_LEN_LO;
                end
                GET_LEN_LO:
                begin
                    fr_length = {8'h00, b};
                    fr_crc    = crc_next(fr_crc, b);
                    fr_phase  = GET_LEN_HI;
                end
                GET_LEN_HI:
                begin
                    fr_length[15:8] = b;
                    fr_crc          = crc_next(fr_crc, b);
                    if (fr_length > BUF_LIMIT)
                        close_frame(ST_TOO_LONG);
                    else
                    begin
                        fr_count = '0;
                        // empty payload goes straight to the CRC bytes
                        fr_phase = (fr_length == 16'd0) ? GET_CRC : GET_PAYLOAD;
                    end
                end
                GET_PAYLOAD:
                begin
                    fr_crc             = crc_next(fr_crc, b);
                    beat.out_kind      = OUT_PAYLOAD;
                    beat.payload_value = b;
                    beat.payload_index = fr_count;
                    deframed_beats.push_back(beat);
                    fr_count++;
                    if (fr_count >= fr_length)
                    begin
                        fr_count = '0;
                        fr_phase = GET_CRC;
                    end
                end
                GET_CRC:
                begin
                    // little-endian CRC, byte lane from the running count
                    fr_crc_rx = fr_crc_rx | ({24'h0, b} << (8 * fr_count[1:0]));
                    fr_count++;
                    if (fr_count >= 9'd4)
                        close_frame(fr_crc_rx == fr_crc ? ST_OK : ST_BAD_CRC);
                end
                default:
                begin
                    if (b == cfg_start)
                    begin
                        fr_phase   = GET_CMD;
                        fr_command = '0;
                        fr_length  = '0;
                        fr_count   = '0;
                        fr_crc     = CRC_INIT;
                        fr_crc_rx  = '0;
                    end
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: pacing of ready and the beat checker
    // ------------------------------------------------------------------------
    initial
    begin : receiver_pacing
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            // a requested hold-off overrides any short stall in progress
            if (hold_off_req != 0)
            begin
                stall_left   = hold_off_req;
                hold_off_req = 0;
            end
            else if (stall_left == 0 && stalls_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 5);
            if (stall_left != 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("mismatch %s: got %0h want %0h (cycle %0d)",
                 what, got, want, cycle_count);
    endtask

    always @(posedge clk)
    begin : beat_check
        result_t got_beat;
        result_t want_beat;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got_beat.out_kind      = res_if.out_kind;
            got_beat.payload_value = res_if.payload_value;
            got_beat.payload_index = res_if.payload_index;
            got_beat.command       = res_if.command;
            got_beat.frame_length  = res_if.frame_length;
            got_beat.status        = res_if.status;
            if (deframed_beats.size() == 0)
                report_mismatch("beat with nothing expected", 32'(got_beat.out_kind),
                                32'h0);
            else
            begin
                want_beat = deframed_beats.pop_front();
                if (got_beat.out_kind != want_beat.out_kind)
                    report_mismatch("out_kind", 32'(got_beat.out_kind),
                                    32'(want_beat.out_kind));
                if (got_beat.payload_value != want_beat.payload_value)
                    report_mismatch("payload_value", 32'(got_beat.payload_value),
                                    32'(want_beat.payload_value));
                if (got_beat.payload_index != want_beat.payload_index)
                    report_mismatch("payload_index", 32'(got_beat.payload_index),
                                    32'(want_beat.payload_index));
                if (got_beat.command != want_beat.command)
                    report_mismatch("command", 32'(got_beat.command),
                                    32'(want_beat.command));
                if (got_beat.frame_length != want_beat.frame_length)
                    report_mismatch("frame_length", 32'(got_beat.frame_length),
                                    32'(want_beat.frame_length));
                if (got_beat.status != want_beat.status)
                    report_mismatch("status", 32'(got_beat.status),
                                    32'(want_beat.status));
            end
        end
    end

    // ------------------------------------------------------------------------
    // rx side: one beat, frames, register writes, draining
    // ------------------------------------------------------------------------
    // Leaves valid high after the handshake so back-to-back beats need no
    // second assignment in the same step.
    task automatic send_beat(input logic k, input logic [7:0] v);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 5);
        if (gap != 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid    <= 1'b1;
        rx_if.kind     <= k;
        rx_if.rx_value <= v;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        deframe_beat(k, v);
    endtask

    // cut: bytes sent after the start byte before the ticks that time it out;
    // negative picks one at random
    task automatic drive_frame(input logic [7:0] cmd, input logic [15:0] len,
                               input frame_fault_e fault, input int cut);
        logic [7:0]  seq[$];
        logic [31:0] crc;
        logic [31:0] mask;
        int          stop;
        int          max_ticks;
        int          n;
        seq = '{cmd, len[7:0], len[15:8]};
        if (fault != FAULT_TOO_LONG)
        begin
            for (int i = 0; i < len; i++)
                seq.push_back(8'($urandom));
            crc = CRC_INIT;
            foreach (seq[i])
                crc = crc_next(crc, seq[i]);
            if (fault == FAULT_CRC)
            begin
                mask = $urandom;
                if (mask == 32'h0)
                    mask = 32'h1;
                crc = crc ^ mask;
            end
            for (int i = 0; i < 4; i++)
                seq.push_back(crc[8*i +: 8]);
        end
        stop = seq.size();
        if (fault == FAULT_TIMEOUT)
            stop = (cut < 0) ? $urandom_range(0, seq.size() - 1) : cut;
        // stray ticks inside a frame stay below the timeout
        max_ticks = (cfg_timeout > 16'd3) ? 3 : int'(cfg_timeout) - 1;

        send_beat(KIND_BYTE, cfg_start);
        frame_items++;
        for (int i = 0; i < stop; i++)
        begin
            if (max_ticks > 0 && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, max_ticks);
                repeat (n)
                begin
                    send_beat(KIND_TICK, 8'($urandom));
                    frame_items++;
                end
            end
            send_beat(KIND_BYTE, seq[i]);
            frame_items++;
        end
        if (fault == FAULT_TIMEOUT)
            repeat (cfg_timeout)
            begin
                send_beat(KIND_TICK, 8'($urandom));
                frame_items++;
            end
    endtask

    // writes both registers, one per cycle; only called with the block idle
    task automatic write_config(input logic [7:0] sb, input logic [15:0] to);
        cfg_we    <= 1'b1;
        cfg_index <= REG_START_BYTE;
        cfg_data  <= {8'h00, sb};
        @(posedge clk);
        cfg_index <= REG_TIMEOUT;
        cfg_data  <= to;
        @(posedge clk);
        cfg_we      <= 1'b0;
        cfg_start   = sb;
        cfg_timeout = to;
        @(posedge clk);
    endtask

    // stop offering, wait for every expected beat, then let beats that give
    // no result clear the pipe
    task automatic wait_drained();
        int waited;
        waited = 0;
        rx_if.valid <= 1'b0;
        while (deframed_beats.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // Reset register values: ignored tick and bytes while hunting, a one-byte
    // good frame, an empty frame with a bad CRC, a length one over the buffer.
    task automatic test_reset_defaults();
        send_beat(KIND_TICK, 8'hFF);
        send_beat(KIND_BYTE, 8'h00);
        send_beat(KIND_BYTE, 8'hFF);
        drive_frame(8'hFF, 16'd1, FAULT_NONE, 0);
        drive_frame(8'h00, 16'd0, FAULT_CRC, 0);
        drive_frame(8'h5A, 16'(BUF_LIMIT + 1), FAULT_TOO_LONG, 0);
        wait_drained();
    endtask

    // Shortest timeout: abort before the command (zeros reported) and after
    // the low length byte (partial length reported). Start byte zero.
    task automatic test_timeout_edges();
        write_config(8'h00, 16'd1);
        send_beat(KIND_TICK, 8'h00);
        drive_frame(8'h3C, 16'd4, FAULT_TIMEOUT, 0);
        drive_frame(8'hC3, 16'd2, FAULT_TIMEOUT, 2);
        wait_drained();
    endtask

    // Receiver holds ready low for a long stretch while the sender keeps
    // offering a payload-heavy frame, so the block fills and stalls rx.
    task automatic test_backpressure();
        write_config(8'hFF, 16'd100);
        gaps_on      = 1'b0;
        hold_off_req = 80;
        drive_frame(8'($urandom), 16'd40, FAULT_NONE, 0);
        gaps_on      = 1'b1;
        wait_drained();
    endtask

    task automatic test_longest_frame();
        write_config(8'hFF, 16'hFFFF);
        drive_frame(8'($urandom), 16'(BUF_LIMIT), FAULT_NONE, 0);
        wait_drained();
    endtask

    // Mostly well-formed frames with random content; some spoilt, some noise
    // between them. Fault timeouts only where the tick count stays short.
    task automatic test_random_frames(input logic [7:0] sb, input logic [15:0] to,
                                      input int target);
        int           r;
        int           n;
        logic [15:0]  len;
        logic [7:0]   v;
        frame_fault_e fault;
        write_config(sb, to);
        frame_items = 0;
        while (frame_items < target)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    if ($urandom_range(0, 1) == 1)
                        send_beat(KIND_TICK, 8'($urandom));
                    else
                    begin
                        v = 8'($urandom);
                        if (v == cfg_start)
                            v = ~v;
                        send_beat(KIND_BYTE, v);
                    end
                end
            end
            r = $urandom_range(0, 99);
            if (r < 70)
                fault = FAULT_NONE;
            else if (r < 82)
                fault = FAULT_CRC;
            else if (r < 92 && cfg_timeout <= 16'd40)
                fault = FAULT_TIMEOUT;
            else
                fault = FAULT_TOO_LONG;
            r = $urandom_range(0, 99);
            if (fault == FAULT_TOO_LONG)
            begin
                if (r < 33)
                    len = 16'(BUF_LIMIT + 1);
                else if (r < 50)
                    len = 16'hFFFF;
                else
                    len = 16'($urandom_range(BUF_LIMIT + 2, 65534));
            end
            else if (r < 4)
                len = 16'($urandom_range(BUF_LIMIT - 1, BUF_LIMIT));
            else if (r < 60)
                len = 16'($urandom_range(0, 8));
            else
                len = 16'($urandom_range(9, 40));
            drive_frame(8'($urandom), len, fault, -1);
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        rx_if.valid    <= 1'b0;
        rx_if.kind     <= KIND_BYTE;
        rx_if.rx_value <= 8'h00;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_START_BYTE;
        cfg_data       <= 16'h0000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_timeout_edges();
        test_backpressure();
        test_longest_frame();
        test_random_frames(8'($urandom), 16'd3, 400);
        test_random_frames(8'hFF, 16'hFFFF, 400);
        test_random_frames(8'($urandom), 16'd20, 400);
        test_random_frames(8'h00, 16'd1, 300);
        // closing stretch at full rate on both sides
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_random_frames(8'($urandom), 16'd7, 400);

        if (deframed_beats.size() != 0)
            report_mismatch("beats never produced", 32'h0, 32'(deframed_beats.size()));
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/crcfr_pkg.sv
rtl/core/crcfr_in_if.sv
rtl/core/crcfr_out_if.sv
rtl/core/crcfr_parser.sv
rtl/core/crc_checked_frame_receiver_unit.sv
verif/crc_checked_frame_receiver_unit_test.sv
